@@ src/smet_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// smet_pkg: shared types and constants for the splitmix entropy tree
// Mix and key constants, op codes, and the command/status bundles that join
// the controller to the datapath.
// ============================================================================
package smet_pkg;

    localparam logic [63:0] MIX_MUL_A   = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL_B   = 64'h94D049BB133111EB;
    localparam logic [63:0] NAME_DOMAIN = 64'h4E414D45444C4F4F;
    localparam logic [63:0] FNV_PRIME   = 64'h00000100000001B3;
    localparam logic [63:0] ROOT_LO_KEY = 64'h524F4F544C4F4F4D;
    localparam logic [63:0] ROOT_HI_KEY = 64'h6D6F6F6C544F4F52;
    localparam logic [63:0] FORK_LO_KEY = 64'h464F524B4C4F4F4D;
    localparam logic [63:0] FORK_HI_KEY = 64'h6D6F6F6C4B524F46;
    localparam logic [63:0] ORD_LO_KEY  = 64'h4F5244494E414C30;
    localparam logic [63:0] ORD_HI_KEY  = 64'h314C414E4944524F;
    localparam logic [63:0] READ_KEY    = 64'h524541444C4F4F4D;

    localparam int unsigned OP_W      = 3;
    localparam int unsigned DATA_W    = 64;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned LEN_W     = 16;

    typedef enum logic [OP_W-1:0] {
        OP_ROOT  = 3'd0,
        OP_AT    = 3'd1,
        OP_READ  = 3'd2,
        OP_FORK  = 3'd3,
        OP_BYTE  = 3'd4
    } op_t;

    // value loaded into the mix register at the start of a mix or FNV step
    typedef enum logic [3:0] {
        SRC_ROOT_LO  = 4'd0,
        SRC_ROOT_HI  = 4'd1,
        SRC_ORD_LO   = 4'd2,
        SRC_ORD_HI   = 4'd3,
        SRC_CHILD_LO = 4'd4,
        SRC_CHILD_HI = 4'd5,
        SRC_READ     = 4'd6,
        SRC_NAME     = 4'd7,
        SRC_ACC_LO   = 4'd8,
        SRC_ACC_HI   = 4'd9
    } src_t;

    // T0/T1/RV take the finished mix, ALO/AHI the raw product
    typedef enum logic [2:0] {
        DST_T0  = 3'd0,
        DST_T1  = 3'd1,
        DST_RV  = 3'd2,
        DST_ALO = 3'd3,
        DST_AHI = 3'd4
    } dst_t;

    typedef enum logic [1:0] {
        MULK_C1  = 2'd0,
        MULK_C2  = 2'd1,
        MULK_FNV = 2'd2
    } mulk_t;

    typedef struct packed {
        logic  latch;
        logic  load_x;
        src_t  src;
        logic  mul_start;
        mulk_t mul_kind;
        logic  store;
        dst_t  dst;
        logic  acc_init;
        logic  commit;
        logic  fork_set;
        logic  fork_clr;
        logic  byte_dec;
        logic  set_rej;
        logic  out_load;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            opd_big;
        logic            opd_zero;
        logic            fork_active;
        logic            last_byte;
        logic            mul_done;
    } sts_t;

endpackage
`default_nettype wire

@@ src/splitmix_entropy_tree.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// splitmix_entropy_tree: counter-based random tree on the SplitMix64 mix
// Keeps a 128-bit entropy pair; root, child, read and named-fork operations
// run as chains of finalizer mixes and FNV steps on one shared multiplier.
// ============================================================================
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  s_      | in        | s_valid / s_ready  | s_op, s_operand, s_name_byte
//  m_      | out       | m_valid / m_ready  | m_read_value, m_entropy_low_out,
//          |           |                    | m_entropy_high_out,
//          |           |                    | m_fork_waiting, m_rejected
//
//  One transaction at a time. Every 64-bit product goes through a single
//  32x32 multiplier in three passes. Reset (aresetn low, synchronous)
//  clears the pair, the accumulator and any pending fork. A result waiting
//  on m_ready holds in the output register while the next transaction is
//  accepted; that transaction finishes its work and then waits for the
//  register to free up.
//
module splitmix_entropy_tree (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [smet_pkg::OP_W-1:0]    s_op,
    input  wire logic [smet_pkg::DATA_W-1:0]  s_operand,
    input  wire logic [smet_pkg::BYTE_W-1:0]  s_name_byte,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [smet_pkg::DATA_W-1:0]       m_read_value,
    output logic [smet_pkg::DATA_W-1:0]       m_entropy_low_out,
    output logic [smet_pkg::DATA_W-1:0]       m_entropy_high_out,
    output logic                              m_fork_waiting,
    output logic                              m_rejected
);

    smet_pkg::cmd_t cmd;
    smet_pkg::sts_t sts;

    // sequencer: decodes the op, walks the mix schedule, owns m_valid
    smet_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // state, mix datapath, shared multiplier and output register
    smet_datapath u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .s_op               (s_op),
        .s_operand          (s_operand),
        .s_name_byte        (s_name_byte),
        .m_read_value       (m_read_value),
        .m_entropy_low_out  (m_entropy_low_out),
        .m_entropy_high_out (m_entropy_high_out),
        .m_fork_waiting     (m_fork_waiting),
        .m_rejected         (m_rejected)
    );

endmodule
`default_nettype wire

@@ src/smet_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// smet_mul: 64x64 multiplier, low 64 bits of the product
// One 32x32 multiplier used over three passes; partial products registered
// and summed in the following cycle.
// ============================================================================
module smet_mul (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic             done,
    output logic [63:0]      p
);

    logic [63:0] a_reg, b_reg;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [31:0] op_a, op_b;

    // step 0: lo*lo, step 1: hi(a)*lo(b), step 2: lo(a)*hi(b)
    assign op_a = (step_reg == 2'd1) ? a_reg[63:32] : a_reg[31:0];
    assign op_b = (step_reg == 2'd2) ? b_reg[63:32] : b_reg[31:0];

    always_comb begin
        prod_next = {32'd0, op_a} * {32'd0, op_b};
        acc_next  = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            step_next = 2'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            step_next = step_reg + 2'd1;
            unique case (step_reg)
                2'd0: ;
                2'd1: acc_next = prod_reg;
                default: acc_next = {acc_reg[63:32] + prod_reg[31:0], acc_reg[31:0]};
            endcase
            if (step_reg == 2'd3) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= a;
            b_reg <= b;
        end
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule
`default_nettype wire

@@ src/smet_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// smet_datapath: entropy pair, name accumulator and mix datapath
// Holds all item state, runs the commands issued by the controller and
// keeps the output register.
// ============================================================================
module smet_datapath (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire smet_pkg::cmd_t               cmd,
    output smet_pkg::sts_t                    sts,
    input  wire logic [smet_pkg::OP_W-1:0]    s_op,
    input  wire logic [smet_pkg::DATA_W-1:0]  s_operand,
    input  wire logic [smet_pkg::BYTE_W-1:0]  s_name_byte,
    output logic [smet_pkg::DATA_W-1:0]       m_read_value,
    output logic [smet_pkg::DATA_W-1:0]       m_entropy_low_out,
    output logic [smet_pkg::DATA_W-1:0]       m_entropy_high_out,
    output logic                              m_fork_waiting,
    output logic                              m_rejected
);

    logic [smet_pkg::OP_W-1:0]   op_reg;
    logic [smet_pkg::DATA_W-1:0] opd_reg;
    logic [smet_pkg::BYTE_W-1:0] byte_reg;
    logic [63:0] elo_reg, ehi_reg, alo_reg, ahi_reg;
    logic [63:0] t0_reg, t1_reg, rv_reg, x_reg;
    logic [smet_pkg::LEN_W-1:0] bytes_left_reg;
    logic        fork_reg, rej_reg;
    logic [63:0] src_val, fin_val, mul_a, mul_b, mul_p;
    logic        mul_done;

    always_comb begin
        unique case (cmd.src)
            smet_pkg::SRC_ROOT_LO:  src_val = opd_reg ^ smet_pkg::ROOT_LO_KEY;
            smet_pkg::SRC_ROOT_HI:  src_val = opd_reg ^ smet_pkg::ROOT_HI_KEY;
            smet_pkg::SRC_ORD_LO:   src_val = opd_reg ^ smet_pkg::ORD_LO_KEY;
            smet_pkg::SRC_ORD_HI:   src_val = opd_reg ^ smet_pkg::ORD_HI_KEY;
            smet_pkg::SRC_CHILD_LO:
                src_val = elo_reg ^ {ehi_reg[46:0], ehi_reg[63:47]} ^ t0_reg;
            smet_pkg::SRC_CHILD_HI:
                src_val = ehi_reg ^ {elo_reg[22:0], elo_reg[63:23]} ^ t1_reg;
            smet_pkg::SRC_READ:
                src_val = t0_reg ^ {t1_reg[40:0], t1_reg[63:41]} ^ smet_pkg::READ_KEY;
            smet_pkg::SRC_NAME:     src_val = opd_reg ^ smet_pkg::NAME_DOMAIN;
            smet_pkg::SRC_ACC_LO:   src_val = alo_reg;
            smet_pkg::SRC_ACC_HI:   src_val = ahi_reg;
            default:                src_val = alo_reg;
        endcase
    end

    always_comb begin
        unique case (cmd.mul_kind)
            smet_pkg::MULK_C1: begin
                mul_a = x_reg ^ (x_reg >> 30);
                mul_b = smet_pkg::MIX_MUL_A;
            end
            smet_pkg::MULK_C2: begin
                mul_a = x_reg ^ (x_reg >> 27);
                mul_b = smet_pkg::MIX_MUL_B;
            end
            default: begin
                mul_a = x_reg ^ {56'd0, byte_reg};
                mul_b = smet_pkg::FNV_PRIME;
            end
        endcase
    end

    assign fin_val = x_reg ^ (x_reg >> 31);

    smet_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .p       (mul_p)
    );

    // control state: fork tracking and the entropy / accumulator registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elo_reg        <= '0;
            ehi_reg        <= '0;
            alo_reg        <= '0;
            ahi_reg        <= '0;
            bytes_left_reg <= '0;
            fork_reg       <= 1'b0;
        end else begin
            if (cmd.commit) begin
                elo_reg <= t0_reg;
                ehi_reg <= t1_reg;
            end
            if (cmd.acc_init) begin
                alo_reg <= elo_reg ^ {ehi_reg[46:0], ehi_reg[63:47]}
                           ^ smet_pkg::FORK_LO_KEY ^ t0_reg;
                ahi_reg <= ehi_reg ^ {elo_reg[22:0], elo_reg[63:23]}
                           ^ smet_pkg::FORK_HI_KEY ^ t0_reg;
            end else if (cmd.store && cmd.dst == smet_pkg::DST_ALO) begin
                alo_reg <= x_reg;
            end else if (cmd.store && cmd.dst == smet_pkg::DST_AHI) begin
                ahi_reg <= x_reg;
            end
            if (cmd.fork_clr) begin
                fork_reg       <= 1'b0;
                bytes_left_reg <= '0;
            end else if (cmd.fork_set) begin
                fork_reg       <= 1'b1;
                bytes_left_reg <= opd_reg[smet_pkg::LEN_W-1:0];
            end else if (cmd.byte_dec) begin
                bytes_left_reg <= bytes_left_reg - 1'b1;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_reg   <= s_op;
            opd_reg  <= s_operand;
            byte_reg <= s_name_byte;
            rv_reg   <= '0;
            rej_reg  <= 1'b0;
        end else begin
            if (cmd.set_rej) begin
                rej_reg <= 1'b1;
            end
            if (cmd.store && cmd.dst == smet_pkg::DST_RV) begin
                rv_reg <= fin_val;
            end
        end
        if (cmd.load_x) begin
            x_reg <= src_val;
        end else if (mul_done) begin
            x_reg <= mul_p;
        end
        if (cmd.store && cmd.dst == smet_pkg::DST_T0) begin
            t0_reg <= fin_val;
        end
        if (cmd.store && cmd.dst == smet_pkg::DST_T1) begin
            t1_reg <= fin_val;
        end
        if (cmd.out_load) begin
            m_read_value       <= rv_reg;
            m_entropy_low_out  <= elo_reg;
            m_entropy_high_out <= ehi_reg;
            m_fork_waiting     <= fork_reg;
            m_rejected         <= rej_reg;
        end
    end

    assign sts.op          = op_reg;
    assign sts.opd_big     = |opd_reg[smet_pkg::DATA_W-1:smet_pkg::LEN_W];
    assign sts.opd_zero    = ~|opd_reg;
    assign sts.fork_active = fork_reg;
    assign sts.last_byte   = (bytes_left_reg == smet_pkg::LEN_W'(1));
    assign sts.mul_done    = mul_done;

endmodule
`default_nettype wire

@@ src/smet_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// smet_ctrl: sequencer for the splitmix entropy tree
// Decodes each transaction into a chain of mixes and FNV steps and drives
// the datapath commands and the output valid.
// ============================================================================
module smet_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  wire logic           m_ready,
    input  wire smet_pkg::sts_t sts,
    output smet_pkg::cmd_t      cmd
);

    typedef enum logic [14:0] {
        ST_IDLE      = 15'b000000000000001,
        ST_DECODE    = 15'b000000000000010,
        ST_LOAD      = 15'b000000000000100,
        ST_GO_A      = 15'b000000000001000,
        ST_WAIT_A    = 15'b000000000010000,
        ST_GO_B      = 15'b000000000100000,
        ST_WAIT_B    = 15'b000000001000000,
        ST_STORE     = 15'b000000010000000,
        ST_ACC_INIT  = 15'b000000100000000,
        ST_COMMIT    = 15'b000001000000000,
        ST_FNV_LOAD  = 15'b000010000000000,
        ST_FNV_GO    = 15'b000100000000000,
        ST_FNV_WAIT  = 15'b001000000000000,
        ST_FNV_STORE = 15'b010000000000000,
        ST_RESULT    = 15'b100000000000000
    } state_t;

    typedef enum logic [2:0] {
        PROG_ROOT = 3'd0,
        PROG_AT   = 3'd1,
        PROG_READ = 3'd2,
        PROG_NAME = 3'd3,
        PROG_FIN  = 3'd4
    } prog_t;

    typedef struct packed {
        smet_pkg::src_t src;
        smet_pkg::dst_t dst;
        logic           last;
    } step_t;

    // mix schedule: source and destination of each mix in a program
    function automatic step_t mix_step(prog_t p, logic [2:0] i);
        step_t s;
        s.src  = smet_pkg::SRC_ACC_LO;
        s.dst  = smet_pkg::DST_T0;
        s.last = 1'b1;
        unique case (p)
            PROG_ROOT: begin
                s.src  = i[0] ? smet_pkg::SRC_ROOT_HI : smet_pkg::SRC_ROOT_LO;
                s.dst  = i[0] ? smet_pkg::DST_T1 : smet_pkg::DST_T0;
                s.last = i[0];
            end
            PROG_AT, PROG_READ: begin
                unique case (i)
                    3'd0: s.src = smet_pkg::SRC_ORD_LO;
                    3'd1: s.src = smet_pkg::SRC_ORD_HI;
                    3'd2: s.src = smet_pkg::SRC_CHILD_LO;
                    3'd3: s.src = smet_pkg::SRC_CHILD_HI;
                    default: s.src = smet_pkg::SRC_READ;
                endcase
                s.dst  = (i == 3'd4) ? smet_pkg::DST_RV
                       : (i[0] ? smet_pkg::DST_T1 : smet_pkg::DST_T0);
                s.last = (p == PROG_AT) ? (i == 3'd3) : (i == 3'd4);
            end
            PROG_NAME: begin
                s.src  = smet_pkg::SRC_NAME;
                s.dst  = smet_pkg::DST_T0;
                s.last = 1'b1;
            end
            default: begin
                s.src  = i[0] ? smet_pkg::SRC_ACC_HI : smet_pkg::SRC_ACC_LO;
                s.dst  = i[0] ? smet_pkg::DST_T1 : smet_pkg::DST_T0;
                s.last = i[0];
            end
        endcase
        return s;
    endfunction

    state_t     state_reg, state_next;
    prog_t      prog_reg, prog_next;
    logic [2:0] idx_reg, idx_next;
    logic       half_reg, half_next;
    logic       m_valid_reg, m_valid_next;
    step_t      cur;

    assign cur = mix_step(prog_reg, idx_reg);

    always_comb begin
        state_next   = state_reg;
        prog_next    = prog_reg;
        idx_next     = idx_reg;
        half_next    = half_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.src      = cur.src;
        cmd.dst      = cur.dst;
        cmd.mul_kind = smet_pkg::MULK_C1;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                idx_next  = '0;
                half_next = 1'b0;
                unique case (sts.op)
                    smet_pkg::OP_ROOT: begin
                        cmd.fork_clr = 1'b1;
                        prog_next    = PROG_ROOT;
                        state_next   = ST_LOAD;
                    end
                    smet_pkg::OP_AT: begin
                        cmd.fork_clr = 1'b1;
                        prog_next    = PROG_AT;
                        state_next   = ST_LOAD;
                    end
                    smet_pkg::OP_READ: begin
                        cmd.fork_clr = 1'b1;
                        prog_next    = PROG_READ;
                        state_next   = ST_LOAD;
                    end
                    smet_pkg::OP_FORK: begin
                        if (sts.opd_big) begin
                            cmd.set_rej = 1'b1;
                            state_next  = ST_RESULT;
                        end else begin
                            prog_next  = PROG_NAME;
                            state_next = ST_LOAD;
                        end
                    end
                    smet_pkg::OP_BYTE: begin
                        if (!sts.fork_active) begin
                            cmd.set_rej = 1'b1;
                            state_next  = ST_RESULT;
                        end else begin
                            state_next = ST_FNV_LOAD;
                        end
                    end
                    default: begin
                        // unused op codes only drop a pending fork
                        cmd.fork_clr = 1'b1;
                        state_next   = ST_RESULT;
                    end
                endcase
            end
            ST_LOAD: begin
                cmd.load_x = 1'b1;
                state_next = ST_GO_A;
            end
            ST_GO_A: begin
                cmd.mul_start = 1'b1;
                cmd.mul_kind  = smet_pkg::MULK_C1;
                state_next    = ST_WAIT_A;
            end
            ST_WAIT_A: begin
                if (sts.mul_done) begin
                    state_next = ST_GO_B;
                end
            end
            ST_GO_B: begin
                cmd.mul_start = 1'b1;
                cmd.mul_kind  = smet_pkg::MULK_C2;
                state_next    = ST_WAIT_B;
            end
            ST_WAIT_B: begin
                if (sts.mul_done) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                cmd.store = 1'b1;
                if (!cur.last) begin
                    idx_next   = idx_reg + 3'd1;
                    state_next = ST_LOAD;
                end else begin
                    unique case (prog_reg)
                        PROG_READ: state_next = ST_RESULT;
                        PROG_NAME: state_next = ST_ACC_INIT;
                        default:   state_next = ST_COMMIT;
                    endcase
                end
            end
            ST_ACC_INIT: begin
                cmd.acc_init = 1'b1;
                if (sts.opd_zero) begin
                    // empty name: finalize right away
                    prog_next  = PROG_FIN;
                    idx_next   = '0;
                    state_next = ST_LOAD;
                end else begin
                    cmd.fork_set = 1'b1;
                    state_next   = ST_RESULT;
                end
            end
            ST_COMMIT: begin
                cmd.commit   = 1'b1;
                cmd.fork_clr = (prog_reg == PROG_FIN);
                state_next   = ST_RESULT;
            end
            ST_FNV_LOAD: begin
                cmd.load_x = 1'b1;
                cmd.src    = half_reg ? smet_pkg::SRC_ACC_HI : smet_pkg::SRC_ACC_LO;
                state_next = ST_FNV_GO;
            end
            ST_FNV_GO: begin
                cmd.mul_start = 1'b1;
                cmd.mul_kind  = smet_pkg::MULK_FNV;
                state_next    = ST_FNV_WAIT;
            end
            ST_FNV_WAIT: begin
                cmd.mul_kind = smet_pkg::MULK_FNV;
                if (sts.mul_done) begin
                    state_next = ST_FNV_STORE;
                end
            end
            ST_FNV_STORE: begin
                cmd.store = 1'b1;
                cmd.dst   = half_reg ? smet_pkg::DST_AHI : smet_pkg::DST_ALO;
                if (!half_reg) begin
                    half_next  = 1'b1;
                    state_next = ST_FNV_LOAD;
                end else begin
                    cmd.byte_dec = 1'b1;
                    if (sts.last_byte) begin
                        prog_next  = PROG_FIN;
                        idx_next   = '0;
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            prog_reg    <= PROG_ROOT;
            idx_reg     <= '0;
            half_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            prog_reg    <= prog_next;
            idx_reg     <= idx_next;
            half_reg    <= half_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

@@ src/smet_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// smet_checker: port-level checks for the splitmix entropy tree
// Watches the top level's ports only; attached by bind.
// ============================================================================
module smet_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_valid,
    input wire logic                         s_ready,
    input wire logic [smet_pkg::OP_W-1:0]    s_op,
    input wire logic [smet_pkg::DATA_W-1:0]  s_operand,
    input wire logic [smet_pkg::BYTE_W-1:0]  s_name_byte,
    input wire logic                         m_valid,
    input wire logic                         m_ready,
    input wire logic [smet_pkg::DATA_W-1:0]  m_read_value,
    input wire logic [smet_pkg::DATA_W-1:0]  m_entropy_low_out,
    input wire logic [smet_pkg::DATA_W-1:0]  m_entropy_high_out,
    input wire logic                         m_fork_waiting,
    input wire logic                         m_rejected
);

    // stalled input transaction holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_op)
            && $stable(s_operand) && $stable(s_name_byte))
        else $error("input changed while stalled");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_value)
            && $stable(m_entropy_low_out) && $stable(m_entropy_high_out)
            && $stable(m_fork_waiting) && $stable(m_rejected))
        else $error("result changed while stalled");

    // nothing comes out in the cycle after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a rejected transaction never carries a read value
    a_rej_no_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rejected |-> m_read_value == '0)
        else $error("rejected transaction with read value");

    // a read cancels any fork, so a waiting fork means no read value
    a_fork_no_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_fork_waiting |-> m_read_value == '0)
        else $error("fork waiting alongside read value");

endmodule

bind splitmix_entropy_tree smet_checker u_smet_checker (.*);
`default_nettype wire

@@ bench/tb_splitmix_entropy_tree.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_splitmix_entropy_tree: self-checking bench for the splitmix entropy tree
// Drives root, child, read and named-fork transactions through the s_ channel.
// An in-bench model of the mix tree predicts every result, and each m_
// transaction is checked field by field against the oldest prediction.
// ============================================================================
module tb_splitmix_entropy_tree;

    import smet_pkg::*;

    // Op codes 5..7 are unused by the block: they drop a pending fork only
    localparam logic [OP_W-1:0] OP_NOP_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_NOP_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_NOP_7 = 3'd7;

    localparam int unsigned  NAME_LEN_MAX  = 65535;
    localparam int unsigned  TARGET_ITEMS  = 1650;
    localparam int unsigned  DRAIN_CYCLES  = 100;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] operand;
        logic [BYTE_W-1:0] name_byte;
    } tree_cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_value;
        logic [DATA_W-1:0] ent_lo;
        logic [DATA_W-1:0] ent_hi;
        logic              waiting;
        logic              rejected;
    } tree_out_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic              s_valid     = 1'b0;
    logic              s_ready;
    logic [OP_W-1:0]   s_op        = '0;
    logic [DATA_W-1:0] s_operand   = '0;
    logic [BYTE_W-1:0] s_name_byte = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    logic [DATA_W-1:0] m_read_value;
    logic [DATA_W-1:0] m_entropy_low_out;
    logic [DATA_W-1:0] m_entropy_high_out;
    logic              m_fork_waiting;
    logic              m_rejected;

    splitmix_entropy_tree u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_op               (s_op),
        .s_operand          (s_operand),
        .s_name_byte        (s_name_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_read_value       (m_read_value),
        .m_entropy_low_out  (m_entropy_low_out),
        .m_entropy_high_out (m_entropy_high_out),
        .m_fork_waiting     (m_fork_waiting),
        .m_rejected         (m_rejected)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Tree model: its own copy of the entropy pair and the fork accumulator
    // ------------------------------------------------------------------------
    logic [DATA_W-1:0] pair_lo   = '0;
    logic [DATA_W-1:0] pair_hi   = '0;
    logic [DATA_W-1:0] acc_lo    = '0;
    logic [DATA_W-1:0] acc_hi    = '0;
    logic [LEN_W-1:0]  name_left = '0;
    logic              fork_open = 1'b0;

    // SplitMix64 finalizer
    function automatic logic [63:0] mix64(input logic [63:0] v);
        logic [63:0] x;
        x = (v ^ (v >> 30)) * MIX_MUL_A;
        x = (x ^ (x >> 27)) * MIX_MUL_B;
        return x ^ (x >> 31);
    endfunction

    function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned r);
        return (v << r) | (v >> (64 - r));
    endfunction

    // child pair of (lo, hi) at an ordinal; shared by "at" and "read"
    function automatic void child_pair(input logic [63:0] lo, input logic [63:0] hi,
                                       input logic [63:0] ord,
                                       output logic [63:0] nlo, output logic [63:0] nhi);
        logic [63:0] olo;
        logic [63:0] ohi;
        olo = mix64(ord ^ ORD_LO_KEY);
        ohi = mix64(ord ^ ORD_HI_KEY);
        nlo = mix64(lo ^ rotl64(hi, 17) ^ olo);
        nhi = mix64(hi ^ rotl64(lo, 41) ^ ohi);
    endfunction

    // Advance the model by one input transaction and return its result
    function automatic tree_out_t tree_step(input tree_cmd_t c);
        tree_out_t   r;
        logic [63:0] clo;
        logic [63:0] chi;
        logic [63:0] len_mix;
        r = '0;
        case (c.op)
            OP_ROOT: begin
                fork_open = 1'b0;
                name_left = '0;
                pair_lo   = mix64(c.operand ^ ROOT_LO_KEY);
                pair_hi   = mix64(c.operand ^ ROOT_HI_KEY);
            end
            OP_AT: begin
                fork_open = 1'b0;
                name_left = '0;
                child_pair(pair_lo, pair_hi, c.operand, clo, chi);
                pair_lo = clo;
                pair_hi = chi;
            end
            OP_READ: begin
                fork_open = 1'b0;
                name_left = '0;
                child_pair(pair_lo, pair_hi, c.operand, clo, chi);
                r.read_value = mix64(clo ^ rotl64(chi, 23) ^ READ_KEY);
            end
            OP_FORK: begin
                if (c.operand > NAME_LEN_MAX) begin
                    r.rejected = 1'b1;   // too long: pending fork survives
                end else begin
                    len_mix = mix64(c.operand ^ NAME_DOMAIN);
                    acc_lo  = pair_lo ^ rotl64(pair_hi, 17) ^ FORK_LO_KEY ^ len_mix;
                    acc_hi  = pair_hi ^ rotl64(pair_lo, 41) ^ FORK_HI_KEY ^ len_mix;
                    if (c.operand == 0) begin
                        // empty name finalizes on the spot
                        pair_lo   = mix64(acc_lo);
                        pair_hi   = mix64(acc_hi);
                        fork_open = 1'b0;
                        name_left = '0;
                    end else begin
                        name_left = c.operand[LEN_W-1:0];
                        fork_open = 1'b1;
                    end
                end
            end
            OP_BYTE: begin
                if (!fork_open) begin
                    r.rejected = 1'b1;   // stray byte
                end else begin
                    acc_lo    = (acc_lo ^ {56'd0, c.name_byte}) * FNV_PRIME;
                    acc_hi    = (acc_hi ^ {56'd0, c.name_byte}) * FNV_PRIME;
                    name_left = name_left - 1'b1;
                    if (name_left == 0) begin
                        pair_lo   = mix64(acc_lo);
                        pair_hi   = mix64(acc_hi);
                        fork_open = 1'b0;
                    end
                end
            end
            default: begin
                fork_open = 1'b0;
                name_left = '0;
            end
        endcase
        r.ent_lo  = pair_lo;
        r.ent_hi  = pair_hi;
        r.waiting = fork_open;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    tree_cmd_t   cmd_q[$];          // transactions not yet driven
    tree_out_t   outcome_q[$];      // predicted results, oldest first
    int unsigned txn_in_count = 0;  // accepted s_ transactions
    int unsigned total_cmds   = 1;
    int unsigned err_count    = 0;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // ordinals/seeds: mix of small, extreme and fully random values
    function automatic logic [63:0] rand_operand();
        case ($urandom_range(0, 5))
            0:       return 64'($urandom_range(0, 15));
            1:       return '1;
            2:       return '0;
            default: return rand64();
        endcase
    endfunction

    // any length that must be refused (above 16 bits)
    function automatic logic [63:0] long_len();
        return rand64() | (64'd1 << $urandom_range(16, 63));
    endfunction

    task automatic push_cmd(input logic [OP_W-1:0] op, input logic [63:0] opd,
                            input logic [7:0] nb);
        tree_cmd_t c;
        c.op        = op;
        c.operand   = opd;
        c.name_byte = nb;
        cmd_q.push_back(c);
    endtask

    // ------------------------------------------------------------------------
    // Backpressure schedule: sender-light/receiver-heavy, then swapped, then
    // a final third with no idling at all
    // ------------------------------------------------------------------------
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    always_comb begin
        if (txn_in_count < total_cmds / 3) begin
            send_idle_pct = 14;
            recv_idle_pct = 65;
        end else if (txn_in_count < 2 * total_cmds / 3) begin
            send_idle_pct = 65;
            recv_idle_pct = 14;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    end

    // Driver: load a new transaction when the channel is empty or just fired
    always @(posedge aclk) begin : drive_proc
        tree_cmd_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (cmd_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = cmd_q.pop_front();
                s_valid     <= 1'b1;
                s_op        <= nxt.op;
                s_operand   <= nxt.operand;
                s_name_byte <= nxt.name_byte;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            err_count++;
        end
    endtask

    // Monitor: predict on input transactions, check on output transactions.
    // Both sampled at the same edge, before any driver update lands.
    always @(posedge aclk) begin : mon_proc
        tree_cmd_t c;
        tree_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                c.op        = s_op;
                c.operand   = s_operand;
                c.name_byte = s_name_byte;
                outcome_q.push_back(tree_step(c));
                txn_in_count++;
            end
            if (m_valid && m_ready) begin
                if (outcome_q.size() == 0) begin
                    $error("result transaction with no prediction pending");
                    err_count++;
                end else begin
                    want = outcome_q.pop_front();
                    check_field("read_value", want.read_value, m_read_value);
                    check_field("entropy_low_out", want.ent_lo, m_entropy_low_out);
                    check_field("entropy_high_out", want.ent_hi, m_entropy_high_out);
                    check_field("fork_waiting", 64'(want.waiting), 64'(m_fork_waiting));
                    check_field("rejected", 64'(want.rejected), 64'(m_rejected));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of test
    // ------------------------------------------------------------------------
    initial begin : main_proc
        int unsigned n_items;
        int unsigned len;
        int unsigned k;
        int unsigned pick;
        bit          cut;

        // Directed: reset pair, extremes, each fork corner
        push_cmd(OP_READ, 64'd0, 8'd0);               // read straight from zero pair
        push_cmd(OP_ROOT, 64'd0, 8'd0);
        push_cmd(OP_ROOT, '1, 8'hFF);
        push_cmd(OP_AT, 64'd0, 8'd0);
        push_cmd(OP_AT, '1, 8'hFF);
        push_cmd(OP_READ, '1, 8'hFF);
        push_cmd(OP_FORK, 64'd0, 8'h00);              // empty name
        push_cmd(OP_BYTE, '1, 8'hFF);                 // stray byte
        push_cmd(OP_FORK, 64'd65536, 8'd0);           // just too long
        push_cmd(OP_FORK, '1, 8'd0);
        push_cmd(OP_FORK, 64'd3, 8'd0);
        push_cmd(OP_BYTE, 64'd0, 8'h00);
        push_cmd(OP_FORK, 64'd70000, 8'd0);           // refused, fork stays pending
        push_cmd(OP_BYTE, '1, 8'hFF);
        push_cmd(OP_BYTE, 64'd0, 8'hA5);              // last byte finalizes
        push_cmd(OP_FORK, 64'd65535, 8'd0);           // longest legal name
        push_cmd(OP_BYTE, rand64(), 8'h5A);
        push_cmd(OP_FORK, 64'd2, 8'd0);               // restart over pending fork
        push_cmd(OP_BYTE, rand64(), 8'h3C);
        push_cmd(OP_NOP_5, '1, 8'hFF);                // unused op drops the fork
        push_cmd(OP_FORK, 64'd2, 8'd0);
        push_cmd(OP_NOP_6, rand64(), 8'd0);
        push_cmd(OP_NOP_7, rand64(), 8'd0);
        push_cmd(OP_FORK, 64'd4, 8'd0);
        push_cmd(OP_READ, rand64(), 8'd0);            // read cancels pending fork
        push_cmd(OP_FORK, 64'd1, 8'd0);
        push_cmd(OP_ROOT, rand64(), 8'd0);            // root cancels pending fork

        // Random: mostly complete forks and tree walks; some noise
        n_items = 0;
        while (n_items < TARGET_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                len = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
                push_cmd(OP_FORK, 64'(len), 8'($urandom));
                n_items++;
                cut = 1'b0;
                for (k = 0; k < len && !cut; k++) begin
                    if ($urandom_range(0, 29) == 0) begin
                        case ($urandom_range(0, 3))
                            0: begin
                                push_cmd(OP_AT, rand_operand(), 8'($urandom));
                                cut = 1'b1;
                            end
                            1: push_cmd(OP_FORK, long_len(), 8'($urandom));
                            2: begin
                                push_cmd(3'($urandom_range(OP_NOP_5, OP_NOP_7)),
                                         rand64(), 8'($urandom));
                                cut = 1'b1;
                            end
                            default: begin
                                push_cmd(OP_FORK, 64'($urandom_range(1, 6)),
                                         8'($urandom));
                                cut = 1'b1;
                            end
                        endcase
                    end
                    if (!cut) begin
                        push_cmd(OP_BYTE, rand64(), 8'($urandom));
                        n_items++;
                    end
                end
            end else if (pick < 82) begin
                push_cmd(3'($urandom_range(OP_ROOT, OP_READ)), rand_operand(),
                         8'($urandom));
                n_items++;
            end else if (pick < 89) begin
                push_cmd(OP_BYTE, rand64(), 8'($urandom));
            end else if (pick < 95) begin
                push_cmd(OP_FORK, long_len(), 8'($urandom));
            end else begin
                push_cmd(3'($urandom_range(OP_NOP_5, OP_NOP_7)), rand64(), 8'($urandom));
            end
        end
        total_cmds = cmd_q.size();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // all input transactions accepted, then all results back, then drain
        do @(posedge aclk); while (cmd_q.size() != 0 || s_valid);
        do @(posedge aclk); while (outcome_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: well past the slowest legal run, stalls included
    initial begin
        #6_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
